FILE: hw/rtl/crb_pkg.sv
package crb_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int ANGLE_BITS   = 16;
    localparam int CHANNELS     = 6;

    // fixed field widths at the ports
    localparam int MASK_W      = 6;
    localparam int TIME_W      = 32;
    localparam int ANGLE_IN_W  = 16;
    localparam int CH_OUT_W    = 3;
    localparam int CNT_OUT_W   = 6;
    localparam int NUM_ANGLE_IN = 6;

    localparam int PTR_W = $clog2(BUFFER_DEPTH);
    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IDX_W = $clog2(NUM_ANGLE_IN);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // channels beyond CHANNELS are never stored
    localparam logic [MASK_W-1:0] SCAN_MASK =
        (CHANNELS >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((1 << CHANNELS) - 1);

    typedef enum logic [1:0] {
        CMD_SCAN,     // scan with at least one channel to store
        CMD_NOTE,     // scan with nothing to store, count only
        CMD_POP
    } t_kind;

    typedef struct packed {
        t_kind                                    kind;
        logic [MASK_W-1:0]                        mask;
        logic [TIME_W-1:0]                        tstamp;
        logic [NUM_ANGLE_IN-1:0][ANGLE_BITS-1:0]  angles;
    } t_cmd;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] angle;
        logic [CH_W-1:0]       chan;
        logic [TIME_W-1:0]     tstamp;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic take;
        logic wr_en;
        logic rd_en;
        logic out_load;
    } t_ctrl;

endpackage

FILE: hw/rtl/crb_front.sv
module crb_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_op,
    input  logic [crb_pkg::MASK_W-1:0]    i_channel_mask,
    input  logic [crb_pkg::TIME_W-1:0]    i_time_stamp,
    input  logic [crb_pkg::ANGLE_IN_W-1:0] i_angle_ch0,
    input  logic [crb_pkg::ANGLE_IN_W-1:0] i_angle_ch1,
    input  logic [crb_pkg::ANGLE_IN_W-1:0] i_angle_ch2,
    input  logic [crb_pkg::ANGLE_IN_W-1:0] i_angle_ch3,
    input  logic [crb_pkg::ANGLE_IN_W-1:0] i_angle_ch4,
    input  logic [crb_pkg::ANGLE_IN_W-1:0] i_angle_ch5,
    output logic                          o_cmd_valid,
    output crb_pkg::t_cmd                 o_cmd,
    input  logic                          i_cmd_take
);
    import crb_pkg::*;

    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_cnt;

    t_cmd              in_cmd;
    logic [MASK_W-1:0] eff_mask;
    logic              push;
    logic              pop;

    // classify the incoming beat
    always_comb begin
        eff_mask         = i_channel_mask & SCAN_MASK;
        in_cmd.mask      = eff_mask;
        in_cmd.tstamp    = i_time_stamp;
        in_cmd.angles[0] = ANGLE_BITS'(i_angle_ch0);
        in_cmd.angles[1] = ANGLE_BITS'(i_angle_ch1);
        in_cmd.angles[2] = ANGLE_BITS'(i_angle_ch2);
        in_cmd.angles[3] = ANGLE_BITS'(i_angle_ch3);
        in_cmd.angles[4] = ANGLE_BITS'(i_angle_ch4);
        in_cmd.angles[5] = ANGLE_BITS'(i_angle_ch5);
        if (i_op) begin
            in_cmd.kind = CMD_POP;
        end else if (eff_mask == '0) begin
            in_cmd.kind = CMD_NOTE;
        end else begin
            in_cmd.kind = CMD_SCAN;
        end
    end

    assign o_in_ready  = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign push        = i_in_valid && o_in_ready;
    assign o_cmd_valid = (r_cnt != '0);
    assign pop         = i_cmd_take && o_cmd_valid;
    assign o_cmd       = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_cnt    = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!push && pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= in_cmd;
        end
    end

endmodule

FILE: hw/rtl/crb_back.sv
module crb_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  crb_pkg::t_cmd                 i_cmd,
    output logic                          o_cmd_take,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_valid_res,
    output logic [crb_pkg::ANGLE_IN_W-1:0] o_angle_out,
    output logic [crb_pkg::CH_OUT_W-1:0]  o_channel_out,
    output logic [crb_pkg::TIME_W-1:0]    o_time_out,
    output logic [crb_pkg::CNT_OUT_W-1:0] o_entry_count
);
    import crb_pkg::*;

    t_entry mem [BUFFER_DEPTH];

    t_state                                  r_state;
    t_state                                  n_state;
    t_ctrl                                   ctrl;
    logic [PTR_W-1:0]                        r_wp;
    logic [PTR_W-1:0]                        r_rp;
    logic [MASK_W-1:0]                       r_mask;
    logic [TIME_W-1:0]                       r_tstamp;
    logic [NUM_ANGLE_IN-1:0][ANGLE_BITS-1:0] r_angles;
    logic                                    r_hit;
    t_entry                                  r_rd;

    logic                  r_out_valid;
    logic                  r_out_hit;
    logic [ANGLE_IN_W-1:0] r_out_angle;
    logic [CH_OUT_W-1:0]   r_out_chan;
    logic [TIME_W-1:0]     r_out_time;
    logic [CNT_OUT_W-1:0]  r_out_cnt;

    logic [IDX_W-1:0]  idx;
    logic [MASK_W-1:0] rest_mask;
    logic [PTR_W-1:0]  wp_nxt;
    logic [PTR_W-1:0]  rp_nxt;
    logic              not_empty;
    logic [PTR_W:0]    cnt_wide;
    logic [PTR_W-1:0]  cnt;

    // lowest pending channel of the scan
    always_comb begin
        idx = '0;
        for (int i = MASK_W - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                idx = IDX_W'(i);
            end
        end
        rest_mask      = r_mask;
        rest_mask[idx] = 1'b0;
    end

    assign wp_nxt    = (r_wp == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign rp_nxt    = (r_rp == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : r_rp + 1'b1;
    assign not_empty = (r_wp != r_rp);

    always_comb begin
        cnt_wide = {1'b0, r_wp} - {1'b0, r_rp};
        if (r_wp < r_rp) begin
            cnt_wide = cnt_wide + (PTR_W + 1)'(BUFFER_DEPTH);
        end
        cnt = cnt_wide[PTR_W-1:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.kind)
                        CMD_SCAN: n_state = ST_SCAN;
                        CMD_POP:  n_state = not_empty ? ST_READ : ST_DONE;
                        default:  n_state = ST_DONE;
                    endcase
                end
            end
            ST_SCAN: begin
                if (rest_mask == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_READ: n_state = ST_DONE;
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        ctrl = '0;
        case (r_state)
            ST_IDLE: begin
                ctrl.take  = i_cmd_valid;
                ctrl.rd_en = i_cmd_valid && (i_cmd.kind == CMD_POP) && not_empty;
            end
            ST_SCAN: ctrl.wr_en = 1'b1;
            ST_DONE: ctrl.out_load = !r_out_valid || i_out_ready;
            default: ctrl = '0;
        endcase
    end

    assign o_cmd_take = ctrl.take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wp        <= '0;
            r_rp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ctrl.wr_en) begin
                r_wp <= wp_nxt;
                // full: drop the oldest
                if (wp_nxt == r_rp) begin
                    r_rp <= rp_nxt;
                end
            end else if (ctrl.rd_en) begin
                r_rp <= rp_nxt;
            end
            if (ctrl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.take) begin
            r_mask   <= i_cmd.mask;
            r_tstamp <= i_cmd.tstamp;
            r_angles <= i_cmd.angles;
            r_hit    <= ctrl.rd_en;
        end else if (ctrl.wr_en) begin
            r_mask <= rest_mask;
        end
        if (ctrl.out_load) begin
            r_out_hit   <= r_hit;
            r_out_angle <= r_hit ? ANGLE_IN_W'(r_rd.angle) : '0;
            r_out_chan  <= r_hit ? CH_OUT_W'(r_rd.chan) : '0;
            r_out_time  <= r_hit ? r_rd.tstamp : '0;
            r_out_cnt   <= CNT_OUT_W'(cnt);
        end
    end

    // sample store, single port
    always_ff @(posedge i_clk) begin
        if (ctrl.wr_en) begin
            mem[r_wp] <= '{angle: r_angles[idx], chan: CH_W'(idx), tstamp: r_tstamp};
        end else if (ctrl.rd_en) begin
            r_rd <= mem[r_rp];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_valid_res   = r_out_hit;
    assign o_angle_out   = r_out_angle;
    assign o_channel_out = r_out_chan;
    assign o_time_out    = r_out_time;
    assign o_entry_count = r_out_cnt;

endmodule

FILE: hw/rtl/channel_sample_ring_buffer.sv
// A scan storing n samples writes them in ST_SCAN; the single-port sample store takes
//   one write per cycle. A pop reads the store and passes ST_READ; a pop of an empty
//   buffer or a scan with no channel goes straight to ST_DONE. Each command ends in
//   ST_DONE, which loads the registered result once the output is free. The sequencer
//   handles one command at a time; a two-beat queue sits in front of it.
// Reset (i_rst_n low, synchronous) empties the buffer and the queue; store contents
//   are not cleared.
module channel_sample_ring_buffer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_op,
    input  logic [crb_pkg::MASK_W-1:0]    i_channel_mask,
    input  logic [crb_pkg::TIME_W-1:0]    i_time_stamp,
    input  logic [crb_pkg::ANGLE_IN_W-1:0] i_angle_ch0,
    input  logic [crb_pkg::ANGLE_IN_W-1:0] i_angle_ch1,
    input  logic [crb_pkg::ANGLE_IN_W-1:0] i_angle_ch2,
    input  logic [crb_pkg::ANGLE_IN_W-1:0] i_angle_ch3,
    input  logic [crb_pkg::ANGLE_IN_W-1:0] i_angle_ch4,
    input  logic [crb_pkg::ANGLE_IN_W-1:0] i_angle_ch5,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_valid_res,
    output logic [crb_pkg::ANGLE_IN_W-1:0] o_angle_out,
    output logic [crb_pkg::CH_OUT_W-1:0]  o_channel_out,
    output logic [crb_pkg::TIME_W-1:0]    o_time_out,
    output logic [crb_pkg::CNT_OUT_W-1:0] o_entry_count
);
    import crb_pkg::*;

    logic cmd_valid;
    logic cmd_take;
    t_cmd cmd;

    crb_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_channel_mask (i_channel_mask),
        .i_time_stamp   (i_time_stamp),
        .i_angle_ch0    (i_angle_ch0),
        .i_angle_ch1    (i_angle_ch1),
        .i_angle_ch2    (i_angle_ch2),
        .i_angle_ch3    (i_angle_ch3),
        .i_angle_ch4    (i_angle_ch4),
        .i_angle_ch5    (i_angle_ch5),
        .o_cmd_valid    (cmd_valid),
        .o_cmd          (cmd),
        .i_cmd_take     (cmd_take)
    );

    crb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd),
        .o_cmd_take    (cmd_take),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_valid_res   (o_valid_res),
        .o_angle_out   (o_angle_out),
        .o_channel_out (o_channel_out),
        .o_time_out    (o_time_out),
        .o_entry_count (o_entry_count)
    );

endmodule

FILE: hw/rtl/crb_checker.sv
module crb_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_out_valid,
    input  logic        i_out_ready,
    input  logic        o_valid_res,
    input  logic [15:0] o_angle_out,
    input  logic [2:0]  o_channel_out,
    input  logic [31:0] o_time_out,
    input  logic [5:0]  o_entry_count
);
    import crb_pkg::*;

    a_reset_no_beat: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_valid_res) && $stable(o_angle_out)
            && $stable(o_channel_out) && $stable(o_time_out) && $stable(o_entry_count))
        else $error("result payload changed while stalled");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_valid_res |->
            o_angle_out == '0 && o_channel_out == '0 && o_time_out == '0)
        else $error("non-pop result carries entry data");

    a_chan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_valid_res |-> int'(o_channel_out) < CHANNELS)
        else $error("popped channel out of range");

endmodule

bind channel_sample_ring_buffer crb_checker u_crb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_valid_res   (o_valid_res),
    .o_angle_out   (o_angle_out),
    .o_channel_out (o_channel_out),
    .o_time_out    (o_time_out),
    .o_entry_count (o_entry_count)
);
